/* rtl/lbp_pkg.sv */
// Shared types, constants and the code function for the 3x3 LBP stream block.
package lbp_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int ROW_W      = 13;
    localparam int Q_DEPTH    = 8;
    localparam int Q_PTR_W    = 3;
    localparam int Q_CNT_W    = 4;

    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [ROW_W-1:0]      RST_FRAME_HEIGHT = 13'd480;
    localparam logic [PIX_W-1:0]      RST_BORDER       = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BORDER_VALUE = 2'd2
    } t_cfg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix up;
        t_pix mid;
        t_pix dn;
    } t_col;

    typedef struct packed {
        t_pix code;
        logic frame_end;
    } t_code_item;

    typedef struct packed {
        logic       push_a;
        logic       push_b;
        t_code_item item_a;
        t_code_item item_b;
    } t_q_push;

    function automatic t_pix lbp_code(input t_col l, input t_col m, input t_col r);
        t_pix c;
        t_pix v;
        c    = m.mid;
        v[7] = l.up  > c;
        v[6] = m.up  > c;
        v[5] = r.up  > c;
        v[4] = r.mid > c;
        v[3] = r.dn  > c;
        v[2] = m.dn  > c;
        v[1] = l.dn  > c;
        v[0] = l.mid > c;
        return v;
    endfunction

endpackage

/* rtl/lbp_if.sv */
// Valid/ready channel interfaces: pixel input, code output, configuration writes.
interface lbp_pix_if import lbp_pkg::*; ();
    logic valid;
    logic ready;
    t_pix pixel;
    logic flush;
    modport source(output valid, pixel, flush, input ready);
    modport sink(input valid, pixel, flush, output ready);
endinterface

interface lbp_code_if import lbp_pkg::*; ();
    logic valid;
    logic ready;
    t_pix code;
    logic frame_end;
    modport source(output valid, code, frame_end, input ready);
    modport sink(input valid, code, frame_end, output ready);
endinterface

interface lbp_cfg_if import lbp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* rtl/lbp_out_q.sv */
// Output queue for LBP codes, takes up to two entries per cycle.
module lbp_out_q import lbp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_q_push            i_push,
    lbp_code_if.source         o_code,
    output logic [Q_CNT_W-1:0] o_count
);

    t_code_item          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wp;
    logic [Q_PTR_W-1:0]  r_rp;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic [Q_CNT_W-1:0]  n_push;
    logic                pop;
    t_code_item          first;

    assign first  = i_push.push_a ? i_push.item_a : i_push.item_b;
    assign n_push = Q_CNT_W'(i_push.push_a) + Q_CNT_W'(i_push.push_b);
    assign pop    = o_code.valid && o_code.ready;

    always_ff @(posedge i_clk) begin
        if (i_push.push_a || i_push.push_b) begin
            r_mem[r_wp] <= first;
        end
        if (i_push.push_a && i_push.push_b) begin
            r_mem[r_wp + Q_PTR_W'(1)] <= i_push.item_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_PTR_W'(n_push);
            r_rp  <= r_rp + Q_PTR_W'(pop);
            r_cnt <= r_cnt + n_push - Q_CNT_W'(pop);
        end
    end

    assign o_code.valid     = r_cnt != '0;
    assign o_code.code      = r_mem[r_rp].code;
    assign o_code.frame_end = r_mem[r_rp].frame_end;
    assign o_count          = r_cnt;

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("output queue overflow");
`endif

endmodule

/* rtl/lbp_3x3_code_stream.sv */
// Top level: 3x3 local binary pattern codes over a raster pixel stream.
// A code passes the stage 1, window and stage 2 registers and the output queue before it is presented at the output.
// Throughput: one pixel per cycle while the output queue has room; the line store is read and written once per pixel.
// Up to two codes come out at a row's last column; the output queue absorbs them.
// Reset: counters cleared, registers to defaults, window to border; line store not cleared.
module lbp_3x3_code_stream import lbp_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lbp_pix_if.sink    i_pix,
    lbp_cfg_if.sink    i_cfg,
    lbp_code_if.source o_code
);

    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int RST_W_EFF = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam logic [AW-1:0] RST_WLAST = AW'(RST_W_EFF - 1);
    localparam logic [Q_CNT_W:0] Q_LIMIT = (Q_CNT_W+1)'(Q_DEPTH - 2);

    // configuration
    logic [AW-1:0]    r_wlast;
    logic [ROW_W-1:0] r_hgt;
    t_pix             r_border;
    logic [31:0]      cfg_w_eff;
    logic             cfg_wr;

    // stage 0 counters
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic             in_img;
    logic             acc;
    logic             go;
    logic             last_col;
    logic             e_a;
    logic             e_b;

    // line store: {upper, middle}
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;
    logic               r_fwd;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic [2*PIX_W-1:0] rd;
    logic [2*PIX_W-1:0] wr_data;

    // stage 1
    logic          r_s1_valid;
    logic [1:0]    r_s1_n;
    logic [AW-1:0] r_s1_addr;
    t_pix          r_s1_pix;
    logic          r_s1_bord;
    logic          r_s1_ge1;
    logic          r_s1_ge2;
    logic          r_s1_c0;
    logic          r_s1_ea;
    logic          r_s1_eb;
    logic          r_s1_fe;
    t_pix          top;
    t_pix          mid;
    t_pix          bot;

    // window and stage 2
    t_col       r_win_l;
    t_col       r_win_m;
    t_col       r_win_r;
    t_col       bcol;
    logic       r_s2_valid;
    logic [1:0] r_s2_n;
    logic       r_s2_ea;
    logic       r_s2_eb;
    logic       r_s2_fe;
    t_q_push    q_push;
    logic [Q_CNT_W-1:0] q_count;
    logic [Q_CNT_W:0]   reserve;

    assign cfg_wr = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (i_cfg.data == '0) begin
            cfg_w_eff = 32'd1;
        end else if (32'(i_cfg.data) > 32'(MAX_WIDTH)) begin
            cfg_w_eff = 32'(MAX_WIDTH);
        end else begin
            cfg_w_eff = 32'(i_cfg.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast  <= RST_WLAST;
            r_hgt    <= RST_FRAME_HEIGHT;
            r_border <= RST_BORDER;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                CFG_FRAME_WIDTH: begin
                    r_wlast <= AW'(cfg_w_eff - 32'd1);
                end
                CFG_FRAME_HEIGHT: begin
                    r_hgt <= (i_cfg.data == '0) ? ROW_W'(1) : ROW_W'(i_cfg.data);
                end
                CFG_BORDER_VALUE: begin
                    r_border <= i_cfg.data[PIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // stage 0: accept, counters, line store read
    assign reserve = {1'b0, q_count} + (Q_CNT_W+1)'(r_s1_n) + (Q_CNT_W+1)'(r_s2_n);
    assign i_pix.ready = i_rst_n && (reserve <= Q_LIMIT);

    assign in_img   = r_row < r_hgt;
    assign acc      = i_pix.valid && i_pix.ready;
    assign go       = acc && !(in_img && i_pix.flush);
    assign last_col = r_col == r_wlast;
    assign e_a      = (r_row != '0) && (r_col != '0);
    assign e_b      = (r_row != '0) && last_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr && (i_cfg.index == CFG_FRAME_WIDTH ||
                                i_cfg.index == CFG_FRAME_HEIGHT)) begin
            r_col <= '0;
            r_row <= '0;
        end else if (go) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= (r_row == r_hgt) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_rd_data <= mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem[r_s1_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_n     <= '0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= go;
            r_s1_n     <= go ? ({1'b0, e_a} + {1'b0, e_b}) : 2'd0;
            // same entry written by the item ahead in this cycle
            r_fwd      <= r_s1_valid && (r_s1_addr == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= wr_data;
        if (go) begin
            r_s1_addr <= r_col;
            r_s1_pix  <= i_pix.pixel;
            r_s1_bord <= !in_img;
            r_s1_ge1  <= r_row != '0;
            r_s1_ge2  <= r_row >= ROW_W'(2);
            r_s1_c0   <= r_col == '0;
            r_s1_ea   <= e_a;
            r_s1_eb   <= e_b;
            r_s1_fe   <= r_row == r_hgt;
        end
    end

    // stage 1: line store write back, window shift
    assign rd      = r_fwd ? r_fwd_data : r_rd_data;
    assign top     = r_s1_ge2 ? rd[2*PIX_W-1:PIX_W] : r_border;
    assign mid     = r_s1_ge1 ? rd[PIX_W-1:0] : r_border;
    assign bot     = r_s1_bord ? r_border : r_s1_pix;
    assign wr_data = {mid, bot};
    assign bcol    = '{up: r_border, mid: r_border, dn: r_border};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_l <= '{up: RST_BORDER, mid: RST_BORDER, dn: RST_BORDER};
            r_win_m <= '{up: RST_BORDER, mid: RST_BORDER, dn: RST_BORDER};
            r_win_r <= '{up: RST_BORDER, mid: RST_BORDER, dn: RST_BORDER};
        end else if (r_s1_valid) begin
            r_win_l <= r_win_m;
            r_win_m <= r_s1_c0 ? bcol : r_win_r;
            r_win_r <= '{up: top, mid: mid, dn: bot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s2_n     <= '0;
        end else begin
            r_s2_valid <= r_s1_valid;
            r_s2_n     <= r_s1_valid ? r_s1_n : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_ea <= r_s1_ea;
            r_s2_eb <= r_s1_eb;
            r_s2_fe <= r_s1_fe;
        end
    end

    // stage 2: codes into the output queue
    always_comb begin
        q_push.push_a           = r_s2_valid && r_s2_ea;
        q_push.push_b           = r_s2_valid && r_s2_eb;
        q_push.item_a.code      = lbp_code(r_win_l, r_win_m, r_win_r);
        q_push.item_a.frame_end = 1'b0;
        q_push.item_b.code      = lbp_code(r_win_m, r_win_r, bcol);
        q_push.item_b.frame_end = r_s2_fe;
    end

    lbp_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_code  (o_code),
        .o_count (q_count)
    );

`ifndef NO_ASSERTIONS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_wlast)
        else $error("column counter past row end");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_hgt)
        else $error("row counter past border row");

    a_fwd_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_fwd) |-> (r_wlast == '0))
        else $error("line store forwarding with width above one");
`endif

endmodule

/* bench/lbp_3x3_code_stream_chk.sv */
// Checker for the 3x3 LBP stream: predicts codes from observed transfers and compares.
`timescale 1ns / 100ps
module lbp_3x3_code_stream_chk import lbp_pkg::*; #(
    parameter int MAX_W = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lbp_pix_if   i_pix,
    lbp_cfg_if   i_cfg,
    lbp_code_if  i_code,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_codes_checked
);

    t_pix                  line_up  [MAX_W];
    t_pix                  line_mid [MAX_W];
    t_col                  win [3];
    logic [CFG_DATA_W-1:0] reg_width;
    logic [CFG_DATA_W-1:0] reg_height;
    t_pix                  reg_border;
    int unsigned           col_pos;
    int unsigned           row_pos;
    t_code_item            expected_codes [$];
    int                    fails = 0;
    int                    checked = 0;

    // neighbors clockwise from upper-left land on bits 7 down to 0
    function automatic t_pix ring_code(input t_col l, input t_col m, input t_col r);
        t_pix ring [8];
        t_pix v;
        ring = '{l.up, m.up, r.up, r.mid, r.dn, m.dn, l.dn, l.mid};
        for (int k = 0; k < 8; k++) begin
            v[7-k] = (ring[k] > m.mid);
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        int unsigned w, h, c, r;
        t_pix        p_up, p_mid, p_dn;
        t_col        border_col;
        t_code_item  want;
        if (!i_rst_n) begin
            reg_width  = RST_FRAME_WIDTH;
            reg_height = RST_FRAME_HEIGHT;
            reg_border = RST_BORDER;
            for (int k = 0; k < 3; k++) begin
                win[k] = '{up: RST_BORDER, mid: RST_BORDER, dn: RST_BORDER};
            end
            col_pos = 0;
            row_pos = 0;
            expected_codes.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_FRAME_WIDTH: begin
                        reg_width = i_cfg.data;
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        reg_height = i_cfg.data;
                        col_pos    = 0;
                        row_pos    = 0;
                    end
                    CFG_BORDER_VALUE: reg_border = i_cfg.data[PIX_W-1:0];
                    default: ;
                endcase
            end

            if (i_pix.valid && i_pix.ready) begin
                w = (reg_width == 0) ? 1 : ((reg_width > MAX_W) ? MAX_W : reg_width);
                h = (reg_height == 0) ? 1 : reg_height;
                c = (col_pos >= w) ? w - 1 : col_pos;
                r = (row_pos > h) ? h : row_pos;
                // flush inside the image is dropped; in the bottom border row every item is taken as a border pixel
                if (r == h || !i_pix.flush) begin
                    border_col = '{up: reg_border, mid: reg_border, dn: reg_border};
                    p_dn  = (r < h) ? i_pix.pixel : reg_border;
                    p_up  = (r >= 2) ? line_up[c] : reg_border;
                    p_mid = (r >= 1) ? line_mid[c] : reg_border;
                    line_up[c]  = p_mid;
                    line_mid[c] = p_dn;
                    if (c == 0) begin
                        win[2] = border_col;
                    end
                    win[0] = win[1];
                    win[1] = win[2];
                    win[2] = '{up: p_up, mid: p_mid, dn: p_dn};
                    if (r >= 1) begin
                        if (c >= 1) begin
                            expected_codes.push_back('{code: ring_code(win[0], win[1], win[2]),
                                                       frame_end: 1'b0});
                        end
                        if (c == w - 1) begin
                            expected_codes.push_back('{code: ring_code(win[1], win[2], border_col),
                                                       frame_end: (r == h)});
                        end
                    end
                    c++;
                    if (c >= w) begin
                        c = 0;
                        r++;
                        if (r > h) begin
                            r = 0;
                        end
                    end
                    col_pos = c;
                    row_pos = r;
                end
            end

            if (i_code.valid && i_code.ready) begin
                checked++;
                if (expected_codes.size() == 0) begin
                    $error("code: unexpected transfer, code %02h frame_end %0b",
                           i_code.code, i_code.frame_end);
                    fails++;
                end else begin
                    want = expected_codes.pop_front();
                    if (i_code.code !== want.code) begin
                        $error("code: expected %02h, actual %02h", want.code, i_code.code);
                        fails++;
                    end
                    if (i_code.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, actual %0b",
                               want.frame_end, i_code.frame_end);
                        fails++;
                    end
                end
            end
        end
        o_fail_count    <= fails;
        o_pending       <= expected_codes.size();
        o_codes_checked <= checked;
    end

endmodule

/* bench/lbp_3x3_code_stream_tb.sv */
// Testbench top: clock, reset, pixel and register stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module lbp_3x3_code_stream_tb import lbp_pkg::*; ();

    localparam int MAX_W          = 4096;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_ITEMS     = 1050;
    localparam int SAT_ITEMS      = 32;

    logic i_clk;
    logic i_rst_n;

    int fail_count;
    int pending;
    int codes_checked;
    int hold_requests = 0;
    int quiet_cycles  = 0;
    int send_burst    = 0;
    bit sender_gaps   = 1'b1;
    int frame_w       = 640;
    int frame_h       = 480;
    int items_sent    = 0;
    int frames_done   = 0;
    int settings      = 0;

    lbp_pix_if  pix_if();
    lbp_cfg_if  cfg_if();
    lbp_code_if code_if();

    lbp_3x3_code_stream #(.MAX_WIDTH(MAX_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_code  (code_if)
    );

    lbp_3x3_code_stream_chk #(.MAX_W(MAX_W)) chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pix           (pix_if),
        .i_cfg           (cfg_if),
        .i_code          (code_if),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_codes_checked (codes_checked)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // mostly short gaps, a few long ones, and now and then a run without any
    function automatic int idle_len(inout int burst);
        int p;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        p = $urandom_range(99);
        if (p < 4) begin
            burst = $urandom_range(100, 30);
            return 0;
        end
        if (p < 50) return 0;
        if (p < 88) return $urandom_range(3, 1);
        if (p < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic t_pix rand_pixel(input t_pix base);
        int p;
        int v;
        p = $urandom_range(99);
        if (p < 40) return t_pix'($urandom_range(255));
        if (p < 50) return 8'd0;
        if (p < 60) return 8'd255;
        // near a common level, so ties with the center show up
        v = int'(base) + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return t_pix'(v);
    endfunction

    task automatic send_item(input t_pix px, input logic fl);
        int gap;
        gap = sender_gaps ? idle_len(send_burst) : 0;
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        pix_if.flush <= fl;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_FRAME_WIDTH:  frame_w = (val == 0) ? 1 : ((val > MAX_W) ? MAX_W : val);
            CFG_FRAME_HEIGHT: frame_h = (val == 0) ? 1 : val;
            default: ;
        endcase
    endtask

    // stop sending and wait until every predicted code has come out
    task automatic settle();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // rows image rows from the frame start; the flush row follows only for a whole frame
    task automatic run_frame(input int rows, input int pause_row);
        t_pix base;
        base = t_pix'($urandom_range(255));
        for (int y = 0; y < rows; y++) begin
            if (y == pause_row) settle();
            for (int x = 0; x < frame_w; x++) begin
                if ($urandom_range(99) < 3) send_item(t_pix'($urandom_range(255)), 1'b1);
                send_item(rand_pixel(base), 1'b0);
                items_sent++;
            end
        end
        if (rows == frame_h) begin
            for (int x = 0; x < frame_w; x++) begin
                if ($urandom_range(99) < 15) send_item(rand_pixel(base), 1'b0);
                else send_item(t_pix'($urandom_range(255)), 1'b1);
                items_sent++;
            end
            frames_done++;
        end
    endtask

    initial begin
        int  p;
        int  phase;
        bit  mid_frame;
        i_rst_n      = 1'b0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        pix_if.flush = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_FRAME_WIDTH;
        cfg_if.data  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x2 frame: extremes, a tie with the center, flush inside the image,
        // pixel in the bottom border row
        write_reg(CFG_BORDER_VALUE, 13'd255);
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        send_item(8'd0, 1'b0);
        send_item(8'hA5, 1'b1);
        send_item(8'd255, 1'b0);
        send_item(8'd128, 1'b0);
        send_item(8'd128, 1'b0);
        send_item(8'd128, 1'b0);
        send_item(8'd127, 1'b0);
        send_item(8'h5A, 1'b1);
        send_item(8'd0, 1'b0);
        send_item(8'hFF, 1'b1);
        settle();
        settings++;

        // zero sizes fall back to a single pixel, border at its low end
        write_reg(CFG_FRAME_WIDTH, 13'd0);
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        write_reg(CFG_BORDER_VALUE, 13'd0);
        send_item(8'd0, 1'b0);
        send_item(8'd0, 1'b1);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        settle();
        settings++;

        // very tall frame, cut short and restarted by the next size write
        write_reg(CFG_BORDER_VALUE, 13'd128);
        write_reg(CFG_FRAME_WIDTH, 13'd2);
        write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd128, 1'b0);
        send_item(8'd128, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        settle();
        settings++;
        mid_frame = 1'b1;

        phase = 0;
        while (items_sent < RAND_ITEMS) begin
            if (phase == 0) begin
                // output held off while the input runs flat out
                write_reg(CFG_FRAME_WIDTH, 13'd16);
                write_reg(CFG_FRAME_HEIGHT, 13'd6);
                write_reg(CFG_BORDER_VALUE, CFG_DATA_W'($urandom_range(255)));
                sender_gaps = 1'b0;
                hold_requests++;
                run_frame(frame_h, -1);
                sender_gaps = 1'b1;
                mid_frame = 1'b0;
            end else begin
                p = $urandom_range(99);
                if (mid_frame || p < 70) begin
                    p = $urandom_range(99);
                    write_reg(CFG_FRAME_WIDTH,
                              (p < 8)  ? 13'd0 :
                              (p < 16) ? 13'd1 :
                              (p < 80) ? CFG_DATA_W'($urandom_range(24, 2)) :
                                         CFG_DATA_W'($urandom_range(64, 25)));
                end
                if ($urandom_range(99) < 70) begin
                    p = $urandom_range(99);
                    write_reg(CFG_FRAME_HEIGHT,
                              (p < 8)  ? 13'd0 :
                              (p < 12) ? CFG_DATA_W'($urandom_range(8191, 4096)) :
                                         CFG_DATA_W'($urandom_range(8, 1)));
                end
                if ($urandom_range(99) < 70) begin
                    p = $urandom_range(99);
                    write_reg(CFG_BORDER_VALUE,
                              (p < 30) ? 13'd0 :
                              (p < 60) ? 13'd255 : CFG_DATA_W'($urandom_range(255)));
                end
                mid_frame = 1'b0;
                if (frame_h > 64) begin
                    run_frame($urandom_range(5, 2), -1);
                    mid_frame = 1'b1;
                end else begin
                    repeat ($urandom_range(2, 1)) begin
                        run_frame(frame_h, (phase == 2) ? frame_h / 2 : -1);
                    end
                    if ($urandom_range(99) < 25) begin
                        run_frame($urandom_range(frame_h - 1), -1);
                        mid_frame = 1'b1;
                    end
                end
            end
            settle();
            settings++;
            phase++;
        end

        // width beyond the line store saturates; a short stretch of its top row
        write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        write_reg(CFG_BORDER_VALUE, CFG_DATA_W'($urandom_range(255)));
        for (int x = 0; x < SAT_ITEMS; x++) begin
            send_item(rand_pixel(8'd128), 1'b0);
            items_sent++;
        end
        settle();
        settings++;

        $display("Covered %0d register settings, %0d complete frames, %0d pixel positions",
                 settings, frames_done, items_sent);
        $display("from single-pixel frames to 64-wide rows and 8191-row heights; %0d codes compared",
                 codes_checked);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        int gap;
        int holds_served;
        int recv_burst;
        holds_served = 0;
        recv_burst   = 0;
        code_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_requests != holds_served) begin
                holds_served++;
                code_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = idle_len(recv_burst);
                code_if.ready <= (gap == 0);
                repeat ((gap == 0) ? 1 : gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (code_if.valid && code_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

/* files.f */
rtl/lbp_pkg.sv
rtl/lbp_if.sv
rtl/lbp_out_q.sv
rtl/lbp_3x3_code_stream.sv
bench/lbp_3x3_code_stream_chk.sv
bench/lbp_3x3_code_stream_tb.sv
